// ===== rtl/rom_ram_bank_controller_defines.svh =====
// Assertion macros for the ROM/RAM bank controller.
// Used by the top level only; needs nothing else.
`ifndef ROM_RAM_BANK_CONTROLLER_DEFINES_SVH
`define ROM_RAM_BANK_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define RRBC_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rrbc: check failed");

// next-cycle implication
`define RRBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rrbc: check failed");

`endif

// ===== rtl/rrbc_pkg.sv =====
// Shared types and constants of the ROM/RAM bank controller.
// No dependencies.
`timescale 1ns / 1ps

package rrbc_pkg;

    // default sizes
    localparam int RAM_BYTES_DEF     = 32768;
    localparam int ROM_BANK_BITS_DEF = 7;

    // fixed field widths
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int ROM_ADDR_W  = 21;
    localparam int ROM_BANK_W  = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_MASK = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RAM_KIND      = 2'd1;

    // reset values
    localparam logic [6:0] ROM_BANK_MASK_RST = 7'h7F;
    localparam logic [1:0] RAM_KIND_RST      = 2'd3;

    localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
    localparam logic [7:0] REFUSED_BYTE   = 8'hFF;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    // bank register selected by address bits 14:13 in 0000-7FFF
    typedef enum logic [1:0] {
        SEL_RAM_ENABLE = 2'd0,
        SEL_LOW_BANK   = 2'd1,
        SEL_HIGH_BANK  = 2'd2,
        SEL_MODE       = 2'd3
    } bank_sel_t;

    // external RAM size codes
    typedef enum logic [1:0] {
        RAM_NONE = 2'd0,
        RAM_2K   = 2'd1,
        RAM_8K   = 2'd2,
        RAM_32K  = 2'd3
    } ram_kind_t;

    // per-word status carried down the pipeline
    typedef struct packed {
        logic                  decoded;
        logic                  rom_select;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  ram_read;
        logic                  ram_refused;
    } acc_info_t;

endpackage

// ===== rtl/rrbc_map.sv =====
// Bank and configuration registers plus address mapping.
// Depends on rrbc_pkg.
`timescale 1ns / 1ps

module rrbc_map #(
    parameter int RAM_BYTES     = rrbc_pkg::RAM_BYTES_DEF,
    parameter int ROM_BANK_BITS = rrbc_pkg::ROM_BANK_BITS_DEF,
    parameter int RAM_AW        = $clog2(RAM_BYTES)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [rrbc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             acc_take,
    input  logic [0:0]                       acc_op,
    input  logic [rrbc_pkg::ADDR_W-1:0]      acc_address,
    input  logic [rrbc_pkg::DATA_W-1:0]      acc_data,
    output rrbc_pkg::acc_info_t              acc_info,
    output logic                             ram_en,
    output logic                             ram_we,
    output logic [RAM_AW-1:0]                ram_addr
);
    import rrbc_pkg::*;

    localparam logic [ROM_BANK_W-1:0] BANK_LIMIT =
        ROM_BANK_W'((1 << ROM_BANK_BITS) - 1);
    localparam logic [15:0] RAM_CAP  = 16'(RAM_BYTES);
    localparam logic [15:0] WIN_SIZE = 16'd8192;

    logic [6:0] rom_bank_mask_reg, rom_bank_mask_next;
    logic [1:0] ram_kind_reg, ram_kind_next;
    logic [4:0] low_bank_reg, low_bank_next;
    logic [1:0] high_bank_reg, high_bank_next;
    logic       ram_mode_reg, ram_mode_next;
    logic       ram_enabled_reg, ram_enabled_next;

    logic                  is_write;
    logic                  in_rom;
    logic                  in_ram;
    logic [4:0]            low_eff;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [15:0]           kind_size;
    logic [15:0]           ram_size;
    logic [15:0]           win_limit;
    logic                  ram_ok;
    logic [1:0]            ram_bank;
    logic [14:0]           ram_lin;
    logic [14:0]           size_mask;

    // register updates from config port and bus writes to 0000-7FFF
    always_comb begin
        rom_bank_mask_next = rom_bank_mask_reg;
        ram_kind_next      = ram_kind_reg;
        low_bank_next      = low_bank_reg;
        high_bank_next     = high_bank_reg;
        ram_mode_next      = ram_mode_reg;
        ram_enabled_next   = ram_enabled_reg;
        if (cfg_we) begin
            if (cfg_index == CFG_ROM_BANK_MASK) begin
                rom_bank_mask_next = cfg_data[6:0];
            end else if (cfg_index == CFG_RAM_KIND) begin
                ram_kind_next = cfg_data[1:0];
            end
        end
        if (acc_take && is_write && in_rom) begin
            case (bank_sel_t'(acc_address[14:13]))
                SEL_RAM_ENABLE: ram_enabled_next = (acc_data == RAM_ENABLE_KEY);
                SEL_LOW_BANK:   low_bank_next    = acc_data[4:0];
                SEL_HIGH_BANK:  high_bank_next   = acc_data[1:0];
                SEL_MODE:       ram_mode_next    = (acc_data != '0);
                default:        ram_mode_next    = ram_mode_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_mask_reg <= ROM_BANK_MASK_RST;
            ram_kind_reg      <= RAM_KIND_RST;
            low_bank_reg      <= 5'd1;
            high_bank_reg     <= 2'd0;
            ram_mode_reg      <= 1'b0;
            ram_enabled_reg   <= 1'b1;
        end else begin
            rom_bank_mask_reg <= rom_bank_mask_next;
            ram_kind_reg      <= ram_kind_next;
            low_bank_reg      <= low_bank_next;
            high_bank_reg     <= high_bank_next;
            ram_mode_reg      <= ram_mode_next;
            ram_enabled_reg   <= ram_enabled_next;
        end
    end

    // ROM address: bank 0 fixed below 4000, banked above
    always_comb begin
        is_write = (acc_op == 1'(OP_WRITE));
        in_rom   = !acc_address[15];
        in_ram   = (acc_address[15:13] == 3'b101);
        low_eff  = (low_bank_reg == 5'd0) ? 5'd1 : low_bank_reg;
        rom_bank = {(ram_mode_reg ? 2'd0 : high_bank_reg), low_eff}
                   & rom_bank_mask_reg & BANK_LIMIT;
    end

    // RAM window: size limit, refusal and wrap by a power-of-two mask
    always_comb begin
        case (ram_kind_t'(ram_kind_reg))
            RAM_NONE: kind_size = 16'd0;
            RAM_2K:   kind_size = 16'd2048;
            RAM_8K:   kind_size = 16'd8192;
            RAM_32K:  kind_size = 16'd32768;
            default:  kind_size = 16'd0;
        endcase
        ram_size  = (kind_size > RAM_CAP) ? RAM_CAP : kind_size;
        win_limit = (ram_size < WIN_SIZE) ? ram_size : WIN_SIZE;
        ram_ok    = ram_enabled_reg && (ram_size != 16'd0)
                    && ({3'b000, acc_address[12:0]} < win_limit);
        ram_bank  = ram_mode_reg ? high_bank_reg : 2'd0;
        ram_lin   = {ram_bank, acc_address[12:0]};
        size_mask = 15'(ram_size - 16'd1);
        ram_addr  = RAM_AW'(ram_lin & size_mask);
        ram_en    = acc_take && in_ram && ram_ok;
        ram_we    = is_write;
    end

    // status for the result word
    always_comb begin
        acc_info.decoded     = in_rom || in_ram;
        acc_info.rom_select  = in_rom && !is_write;
        acc_info.rom_address = '0;
        if (in_rom && !is_write) begin
            if (!acc_address[14]) begin
                acc_info.rom_address = {7'd0, acc_address[13:0]};
            end else begin
                acc_info.rom_address = {rom_bank, acc_address[13:0]};
            end
        end
        acc_info.ram_read    = in_ram && !is_write && ram_ok;
        acc_info.ram_refused = in_ram && !is_write && !ram_ok;
    end

endmodule

// ===== rtl/rrbc_ram.sv =====
// Single-port external RAM store with registered read data.
// Depends on rrbc_pkg.
`timescale 1ns / 1ps

module rrbc_ram #(
    parameter int RAM_BYTES = rrbc_pkg::RAM_BYTES_DEF,
    parameter int RAM_AW    = $clog2(RAM_BYTES)
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic                        we,
    input  logic [RAM_AW-1:0]           addr,
    input  logic [rrbc_pkg::DATA_W-1:0] wdata,
    output logic [rrbc_pkg::DATA_W-1:0] rdata
);
    import rrbc_pkg::*;

    logic [DATA_W-1:0] mem [RAM_BYTES];
    logic [DATA_W-1:0] rdata_reg;

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rom_ram_bank_controller.sv =====
// Top level of the ROM/RAM bank controller: pipeline and output stage.
// Depends on rrbc_pkg, rrbc_map, rrbc_ram and the defines header.
//
// Usage:
//   s_* channel takes one CPU bus access per word (op, address, data).
//   m_* channel returns one result word per access, in order: RAM read
//   data (0xFF when refused), ROM select, physical ROM address, decoded.
//   cfg_* channel writes rom_bank_mask (index 0) and ram_kind (index 1);
//   cfg_ready is always high. Write config only while the block is idle.
// Timing:
//   Words pass the RAM stage, then the output stage. One word per cycle is
//   sustained while m_ready is high; the single RAM port does one access per
//   cycle. Bank registers update at the accepting edge; the next word sees them.
// Reset (aresetn low, synchronous): bank and config registers return to
//   their defaults and the pipeline empties. RAM contents are undefined
//   until written.
// Stalls: with m_ready low the output word holds and one more word can be
//   taken into the RAM stage; s_ready drops once both stages are full.
`timescale 1ns / 1ps
`include "rom_ram_bank_controller_defines.svh"

module rom_ram_bank_controller #(
    parameter int RAM_BYTES     = rrbc_pkg::RAM_BYTES_DEF,
    parameter int ROM_BANK_BITS = rrbc_pkg::ROM_BANK_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rrbc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrbc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [0:0]                       s_op,
    input  logic [rrbc_pkg::ADDR_W-1:0]      s_address,
    input  logic [rrbc_pkg::DATA_W-1:0]      s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rrbc_pkg::DATA_W-1:0]      m_read_data,
    output logic [0:0]                       m_rom_select,
    output logic [rrbc_pkg::ROM_ADDR_W-1:0]  m_rom_address,
    output logic [0:0]                       m_decoded
);
    import rrbc_pkg::*;

    localparam int RAM_AW = $clog2(RAM_BYTES);

    logic              s_take;
    acc_info_t         acc_info;
    logic              ram_en;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_addr;
    logic [DATA_W-1:0] ram_rdata;

    logic              s1_valid_reg, s1_valid_next;
    acc_info_t         s1_info_reg;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_rd_reg, out_rd_next;
    logic              out_rsel_reg;
    logic [ROM_ADDR_W-1:0] out_raddr_reg;
    logic              out_dec_reg;
    logic              advance;

    assign cfg_ready = 1'b1;

    // handshake between stages
    assign advance = s1_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    rrbc_map #(
        .RAM_BYTES     (RAM_BYTES),
        .ROM_BANK_BITS (ROM_BANK_BITS),
        .RAM_AW        (RAM_AW)
    ) u_map (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .acc_take    (s_take),
        .acc_op      (s_op),
        .acc_address (s_address),
        .acc_data    (s_data),
        .acc_info    (acc_info),
        .ram_en      (ram_en),
        .ram_we      (ram_we),
        .ram_addr    (ram_addr)
    );

    rrbc_ram #(
        .RAM_BYTES (RAM_BYTES),
        .RAM_AW    (RAM_AW)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (s_data),
        .rdata (ram_rdata)
    );

    // next state of both stages
    always_comb begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance) begin
            s1_valid_next = 1'b0;
        end
        if (s_take) begin
            s1_valid_next = 1'b1;
        end
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end
        if (s1_info_reg.ram_read) begin
            out_rd_next = ram_rdata;
        end else if (s1_info_reg.ram_refused) begin
            out_rd_next = REFUSED_BYTE;
        end else begin
            out_rd_next = '0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_take) begin
            s1_info_reg <= acc_info;
        end
        if (advance) begin
            out_rd_reg    <= out_rd_next;
            out_rsel_reg  <= s1_info_reg.rom_select;
            out_raddr_reg <= s1_info_reg.rom_address;
            out_dec_reg   <= s1_info_reg.decoded;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_read_data   = out_rd_reg;
    assign m_rom_select  = out_rsel_reg;
    assign m_rom_address = out_raddr_reg;
    assign m_decoded     = out_dec_reg;

    // checks
    `RRBC_ASSERT(a_stall_only_full, aclk, aresetn, !s_ready, s1_valid_reg && out_valid_reg)
    `RRBC_ASSERT_NEXT(a_s1_holds, aclk, aresetn, s1_valid_reg && !advance, s1_valid_reg)
    `RRBC_ASSERT(a_rom_word_clean, aclk, aresetn, m_valid && m_rom_select, m_decoded && (m_read_data == 8'h00))

endmodule
